// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the timer control RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/ktsc_pkg.sv -----
// ----------------------------------------------------------------------------
// ktsc_pkg
// Types, constants and helper functions of the timer and stopwatch control.
// ----------------------------------------------------------------------------
package ktsc_pkg;

    localparam int unsigned TIME_BITS   = 24;
    localparam int unsigned KIND_W      = 3;
    localparam int unsigned VALUE_W     = 24;
    localparam int unsigned OUT_BITS    = 24;
    localparam int unsigned STEP_W      = 10;
    localparam int unsigned FMT_W       = TIME_BITS + 1;
    localparam int unsigned PROD_W      = 2 * TIME_BITS + 1;
    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 56;
    localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - 2 * OUT_BITS - 2;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [OUT_BITS-1:0]  OUT_MAX  = '1;

    localparam int unsigned LIM_STEP_15  = 60 * 2;
    localparam int unsigned LIM_STEP_30  = 60 * 5;
    localparam int unsigned LIM_STEP_60  = 60 * 30;
    localparam int unsigned LIM_STEP_300 = 60 * 60;

    localparam logic [STEP_W-1:0] STEP_15  = STEP_W'(15);
    localparam logic [STEP_W-1:0] STEP_30  = STEP_W'(30);
    localparam logic [STEP_W-1:0] STEP_60  = STEP_W'(60);
    localparam logic [STEP_W-1:0] STEP_300 = STEP_W'(60 * 5);
    localparam logic [STEP_W-1:0] STEP_600 = STEP_W'(60 * 10);
    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);

    localparam int unsigned SEC_PER_MIN  = 60;
    localparam int unsigned SEC_PER_HOUR = 3600;
    localparam int unsigned DEC_SCALE    = 100;

    localparam int unsigned DIV60_SHIFT   = TIME_BITS + 6;
    localparam int unsigned DIV3600_SHIFT = TIME_BITS + 12;
    localparam logic [63:0] RECIP_60   = (64'd1 << DIV60_SHIFT) / 64'd60;
    localparam logic [63:0] RECIP_3600 = (64'd1 << DIV3600_SHIFT) / 64'd3600;

    typedef enum logic [KIND_W-1:0] {
        KIND_START     = 3'd0,
        KIND_STOP      = 3'd1,
        KIND_STEP_UP   = 3'd2,
        KIND_STEP_DOWN = 3'd3,
        KIND_TICK_DOWN = 3'd4,
        KIND_TICK_UP   = 3'd5,
        KIND_SET_PROG  = 3'd6
    } t_kind;

    typedef struct packed {
        logic [TIME_BITS-1:0] raw_time;
        logic [TIME_BITS-1:0] prog_time;
        logic                 running;
        logic                 stopwatch;
        logic                 fmt;
    } t_res;

    function automatic logic [STEP_W-1:0] step_size(input logic [TIME_BITS-1:0] t);
        logic [32:0] tw;
        tw = 33'(t);
        if (tw < 33'(LIM_STEP_15)) begin
            return STEP_15;
        end else if (tw < 33'(LIM_STEP_30)) begin
            return STEP_30;
        end else if (tw < 33'(LIM_STEP_60)) begin
            return STEP_60;
        end else if (tw < 33'(LIM_STEP_300)) begin
            return STEP_300;
        end
        return STEP_600;
    endfunction

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                      input logic [STEP_W-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + (TIME_BITS + 1)'(b);
        return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] floor_sub(input logic [TIME_BITS-1:0] a,
                                                        input logic [STEP_W-1:0] b);
        logic [TIME_BITS-1:0] bw;
        bw = TIME_BITS'(b);
        return (a > bw) ? a - bw : '0;
    endfunction

    function automatic logic [TIME_BITS-1:0] sat_value(input logic [VALUE_W-1:0] v);
        return (33'(v) > 33'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(v);
    endfunction

    function automatic logic [OUT_BITS-1:0] clip_out(input logic [32:0] v);
        return (v > 33'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(v);
    endfunction

endpackage

// ----- rtl/core/ktsc_state.sv -----
// ----------------------------------------------------------------------------
// ktsc_state
// Input register, timer state and result register of the event path.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ktsc_state (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ktsc_pkg::KIND_W-1:0]    i_kind,
    input  logic [ktsc_pkg::VALUE_W-1:0]   i_value,
    input  logic                           i_formatted,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output ktsc_pkg::t_res                 o_res
);
    import ktsc_pkg::*;

    logic                 r_in_valid;
    logic [KIND_W-1:0]    r_in_kind;
    logic [VALUE_W-1:0]   r_in_value;
    logic                 r_in_fmt;

    logic [TIME_BITS-1:0] r_prog;
    logic [TIME_BITS-1:0] r_cur;
    logic                 r_counting;
    logic                 r_stopwatch;

    logic [TIME_BITS-1:0] n_prog;
    logic [TIME_BITS-1:0] n_cur;
    logic                 n_counting;
    logic                 n_stopwatch;

    logic                 r_res_valid;
    t_res                 r_res;
    t_res                 n_res;

    logic                 res_ready;
    logic                 move;
    logic [STEP_W-1:0]    step;

    assign res_ready  = !r_res_valid || i_res_ready;
    assign o_in_ready = !r_in_valid || res_ready;
    assign move       = r_in_valid && res_ready;
    assign step       = step_size(r_counting ? r_cur : r_prog);

    always_comb begin
        n_prog      = r_prog;
        n_cur       = r_cur;
        n_counting  = r_counting;
        n_stopwatch = r_stopwatch;
        unique case (r_in_kind)
            KIND_START: begin
                n_stopwatch = (r_prog == '0);
                n_counting  = 1'b1;
                n_cur       = r_prog;
            end
            KIND_STOP: begin
                n_counting = 1'b0;
            end
            KIND_STEP_UP: begin
                if (r_counting) begin
                    n_cur = sat_add(r_cur, step);
                end
                if (!r_counting || !r_stopwatch) begin
                    n_prog = sat_add(r_prog, step);
                end
            end
            KIND_STEP_DOWN: begin
                if (r_counting) begin
                    n_cur = floor_sub(r_cur, step);
                end
                if (!r_counting || !r_stopwatch) begin
                    n_prog = floor_sub(r_prog, step);
                end
            end
            KIND_TICK_DOWN: begin
                n_cur = floor_sub(r_cur, STEP_ONE);
            end
            KIND_TICK_UP: begin
                n_cur = sat_add(r_cur, STEP_ONE);
            end
            KIND_SET_PROG: begin
                n_prog = sat_value(r_in_value);
            end
            default: begin
            end
        endcase

        n_res.raw_time  = n_counting ? n_cur : n_prog;
        n_res.prog_time = n_prog;
        n_res.running   = n_counting;
        n_res.stopwatch = n_stopwatch;
        n_res.fmt       = r_in_fmt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_prog      <= '0;
            r_cur       <= '0;
            r_counting  <= 1'b0;
            r_stopwatch <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (res_ready) begin
                r_res_valid <= r_in_valid;
            end
            if (move) begin
                r_prog      <= n_prog;
                r_cur       <= n_cur;
                r_counting  <= n_counting;
                r_stopwatch <= n_stopwatch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_kind  <= i_kind;
            r_in_value <= i_value;
            r_in_fmt   <= i_formatted;
        end
        if (move) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `ASSERT_CLK(a_start_runs, (move && r_in_kind == KIND_START) |=> r_counting,
        "Timer is not counting after a start event.")
    `ASSERT_CLK(a_state_holds, !move |=> $stable(r_prog) && $stable(r_cur),
        "Timer state changed without an event transfer.")
    `ASSERT_RST(a_reset_clear, !i_rst_n |=> !r_res_valid && !r_in_valid && !r_counting,
        "Control state is not clear after reset.")

endmodule

// ----- rtl/core/ktsc_fmt.sv -----
// ----------------------------------------------------------------------------
// ktsc_fmt
// Three stage display formatter and output register of the result path.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ktsc_fmt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  ktsc_pkg::t_res                  i_res,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [ktsc_pkg::OUT_BITS-1:0]   o_shown,
    output logic [ktsc_pkg::OUT_BITS-1:0]   o_program,
    output logic                            o_running,
    output logic                            o_stopwatch
);
    import ktsc_pkg::*;

    logic                   r_s1_valid;
    t_res                   r_s1_res;
    logic [TIME_BITS-1:0]   r_s1_q60;
    logic [TIME_BITS-1:0]   r_s1_q3600;

    logic                   r_s2_valid;
    t_res                   r_s2_res;
    logic [TIME_BITS-1:0]   r_s2_q60;
    logic [TIME_BITS-1:0]   r_s2_hr;
    logic [5:0]             r_s2_sec;

    logic                   r_s3_valid;
    logic [OUT_BITS-1:0]    r_s3_shown;
    logic [OUT_BITS-1:0]    r_s3_program;
    logic                   r_s3_running;
    logic                   r_s3_stopwatch;

    logic                   rdy1;
    logic                   rdy2;
    logic                   rdy3;

    logic [PROD_W-1:0]      prod60;
    logic [PROD_W-1:0]      prod3600;
    logic [TIME_BITS+5:0]   rem60_w;
    logic [TIME_BITS+11:0]  rem3600_w;
    logic [6:0]             rem60;
    logic [TIME_BITS-1:0]   n_q60;
    logic [TIME_BITS-1:0]   n_hr;
    logic [5:0]             n_sec;

    logic [TIME_BITS-1:0]   min_w;
    logic [FMT_W-1:0]       fmt_low;
    logic [FMT_W-1:0]       fmt_high;
    logic [FMT_W-1:0]       fmt_val;
    logic [OUT_BITS-1:0]    n_shown;

    assign rdy3    = !r_s3_valid || i_ready;
    assign rdy2    = !r_s2_valid || rdy3;
    assign rdy1    = !r_s1_valid || rdy2;
    assign o_ready = rdy1;

    assign prod60   = PROD_W'(i_res.raw_time) * PROD_W'(RECIP_60);
    assign prod3600 = PROD_W'(i_res.raw_time) * PROD_W'(RECIP_3600);

    always_comb begin
        rem60_w   = (TIME_BITS + 6)'(r_s1_res.raw_time)
                  - (TIME_BITS + 6)'(r_s1_q60) * (TIME_BITS + 6)'(SEC_PER_MIN);
        rem3600_w = (TIME_BITS + 12)'(r_s1_res.raw_time)
                  - (TIME_BITS + 12)'(r_s1_q3600) * (TIME_BITS + 12)'(SEC_PER_HOUR);
        rem60     = rem60_w[6:0];
        if (rem60 >= 7'(SEC_PER_MIN)) begin
            n_q60 = r_s1_q60 + TIME_BITS'(1);
            n_sec = 6'(rem60 - 7'(SEC_PER_MIN));
        end else begin
            n_q60 = r_s1_q60;
            n_sec = rem60[5:0];
        end
        if (rem3600_w >= (TIME_BITS + 12)'(SEC_PER_HOUR)) begin
            n_hr = r_s1_q3600 + TIME_BITS'(1);
        end else begin
            n_hr = r_s1_q3600;
        end
    end

    always_comb begin
        min_w    = r_s2_q60 - r_s2_hr * TIME_BITS'(SEC_PER_MIN);
        fmt_low  = FMT_W'(min_w[5:0]) * FMT_W'(DEC_SCALE) + FMT_W'(r_s2_sec);
        fmt_high = FMT_W'(r_s2_hr) * FMT_W'(DEC_SCALE) + FMT_W'(min_w[5:0]);
        fmt_val  = (r_s2_hr == '0) ? fmt_low : fmt_high;
        n_shown  = r_s2_res.fmt ? clip_out(33'(fmt_val)) : clip_out(33'(r_s2_res.raw_time));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_valid <= i_valid;
            end
            if (rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (rdy3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_s1_res   <= i_res;
            r_s1_q60   <= TIME_BITS'(prod60 >> DIV60_SHIFT);
            r_s1_q3600 <= TIME_BITS'(prod3600 >> DIV3600_SHIFT);
        end
        if (rdy2 && r_s1_valid) begin
            r_s2_res <= r_s1_res;
            r_s2_q60 <= n_q60;
            r_s2_hr  <= n_hr;
            r_s2_sec <= n_sec;
        end
        if (rdy3 && r_s2_valid) begin
            r_s3_shown     <= n_shown;
            r_s3_program   <= clip_out(33'(r_s2_res.prog_time));
            r_s3_running   <= r_s2_res.running;
            r_s3_stopwatch <= r_s2_res.stopwatch;
        end
    end

    assign o_valid     = r_s3_valid;
    assign o_shown     = r_s3_shown;
    assign o_program   = r_s3_program;
    assign o_running   = r_s3_running;
    assign o_stopwatch = r_s3_stopwatch;

    `ASSERT_CLK(a_sec_range, r_s2_valid |-> r_s2_sec < 6'(SEC_PER_MIN),
        "Seconds digit pair is out of range.")
    `ASSERT_CLK(a_min_range, r_s2_valid |-> min_w < TIME_BITS'(SEC_PER_MIN),
        "Minutes digit pair is out of range.")
    `ASSERT_RST(a_reset_clear, !i_rst_n |=> !r_s1_valid && !r_s2_valid && !r_s3_valid,
        "Formatter stages are not empty after reset.")

endmodule

// ----- rtl/core/kitchen_timer_stopwatch_control_top.sv -----
// ----------------------------------------------------------------------------
// kitchen_timer_stopwatch_control_top
// Countdown timer and stopwatch control with a streaming event port.
// ----------------------------------------------------------------------------
// Each event transfer (start, stop, step up, step down, tick down, tick up or
// set program time) returns one result transfer carrying the shown time, the
// program time and the running and stopwatch flags. The block takes one event
// in every clock cycle while the output is not stalled; the timer state update
// is combinational, so consecutive events see each other's effect with no gap.
// A result passes in order through the input register, the state update and
// result register, and the three formatter stages that split the time into
// hours, minutes and seconds with constant reciprocal multipliers. Stalls on
// the output side back up through the stages, and every stage keeps taking
// data while it has room.

module kitchen_timer_stopwatch_control_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // value [23:0], formatted [24], zero padding above.
    input  logic [ktsc_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // kind [2:0].
    input  logic [ktsc_pkg::KIND_W-1:0]          i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // shown_time [23:0], program_setting [47:24], running [48],
    // stopwatch_mode [49], zero padding above.
    output logic [ktsc_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);
    import ktsc_pkg::*;

    logic                res_valid;
    logic                res_ready;
    t_res                res;
    logic [OUT_BITS-1:0] shown;
    logic [OUT_BITS-1:0] prog_time;
    logic                running;
    logic                stopwatch;

    ktsc_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_kind      (i_s_axis_tuser),
        .i_value     (i_s_axis_tdata[VALUE_W-1:0]),
        .i_formatted (i_s_axis_tdata[VALUE_W]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    ktsc_fmt u_fmt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (res_valid),
        .o_ready     (res_ready),
        .i_res       (res),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_shown     (shown),
        .o_program   (prog_time),
        .o_running   (running),
        .o_stopwatch (stopwatch)
    );

    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, stopwatch, running, prog_time, shown};

endmodule

// ----- test/kitchen_timer_stopwatch_control_top_tb.sv -----
// ----------------------------------------------------------------------------
// kitchen_timer_stopwatch_control_top_tb
// Self-checking bench for the timer and stopwatch control block.
// ----------------------------------------------------------------------------
// Timer events are sent over the event stream. A short table covers reset
// state, saturation at the largest time, the step-size bands, stopwatch
// selection and the unused kind. A long random run of countdown, stopwatch,
// editing and noise sequences follows. A local timer model predicts each
// result that a table row does not fix. Both stream sides idle at random. Once,
// the output side holds off long enough to back up the block, and the sender
// drains between phases.

module kitchen_timer_stopwatch_control_top_tb;
    import ktsc_pkg::*;

    localparam logic [KIND_W-1:0]    KIND_UNUSED    = 3'd7;
    localparam logic [TIME_BITS-1:0] TIME_CAP       = '1;
    localparam int unsigned          EVENT_TARGET   = 1850;
    localparam int unsigned          HOLD_AT_EVENT  = 900;
    localparam int unsigned          RX_HOLD_CYCLES = 300;
    localparam int unsigned          SETTLE_CYCLES  = 20;
    localparam int unsigned          REPORT_LIMIT   = 10;
    localparam int unsigned          DIR_ROWS_N     = 25;

    typedef struct packed {
        logic [OUT_BITS-1:0] shown;
        logic [OUT_BITS-1:0] prog_time;
        logic                running;
        logic                stopwatch;
    } t_timer_view;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               fmt;
        logic               fixed;
        t_timer_view        view;
    } t_timer_row;

    localparam t_timer_row DIR_ROWS [DIR_ROWS_N] = '{
        '{KIND_STOP,      24'd0,        1'b0, 1'b1, '{24'd0, 24'd0, 1'b0, 1'b0}},
        '{KIND_START,     24'd0,        1'b0, 1'b1, '{24'd0, 24'd0, 1'b1, 1'b1}},
        '{KIND_TICK_UP,   24'd0,        1'b1, 1'b0, '0},
        '{KIND_TICK_DOWN, 24'd0,        1'b0, 1'b0, '0},
        '{KIND_TICK_DOWN, 24'd0,        1'b0, 1'b0, '0},
        '{KIND_STEP_UP,   24'd0,        1'b0, 1'b0, '0},
        '{KIND_STEP_DOWN, 24'd0,        1'b1, 1'b0, '0},
        '{KIND_STOP,      24'd0,        1'b0, 1'b0, '0},
        '{KIND_SET_PROG,  24'hFFFFFF,   1'b1, 1'b1,
          '{24'd466020, 24'hFFFFFF, 1'b0, 1'b1}},
        '{KIND_STEP_UP,   24'd0,        1'b0, 1'b0, '0},
        '{KIND_START,     24'd0,        1'b1, 1'b0, '0},
        '{KIND_TICK_UP,   24'd0,        1'b0, 1'b0, '0},
        '{KIND_STEP_UP,   24'd0,        1'b0, 1'b0, '0},
        '{KIND_STEP_DOWN, 24'd0,        1'b1, 1'b0, '0},
        '{KIND_SET_PROG,  24'd0,        1'b0, 1'b0, '0},
        '{KIND_STEP_DOWN, 24'd0,        1'b0, 1'b0, '0},
        '{KIND_UNUSED,    24'hFFFFFF,   1'b1, 1'b0, '0},
        '{KIND_STOP,      24'd0,        1'b0, 1'b0, '0},
        '{KIND_SET_PROG,  24'd119,      1'b1, 1'b0, '0},
        '{KIND_STEP_UP,   24'd0,        1'b1, 1'b0, '0},
        '{KIND_SET_PROG,  24'd299,      1'b0, 1'b0, '0},
        '{KIND_STEP_UP,   24'd0,        1'b1, 1'b0, '0},
        '{KIND_SET_PROG,  24'd3600,     1'b0, 1'b0, '0},
        '{KIND_STEP_DOWN, 24'd0,        1'b1, 1'b0, '0},
        '{KIND_STEP_DOWN, 24'd0,        1'b1, 1'b0, '0}
    };

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic [KIND_W-1:0]      i_s_axis_tuser  = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    logic [TIME_BITS-1:0] tmr_prog;
    logic [TIME_BITS-1:0] tmr_cur;
    logic                 tmr_running;
    logic                 tmr_stopwatch;

    t_timer_view expected_views [$];
    int unsigned events_sent;
    int unsigned views_checked;
    int unsigned mismatch_count;
    int unsigned kind_hits [8];
    bit          rx_hold_req;
    bit          tx_calm;

    kitchen_timer_stopwatch_control_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned stride_for(input logic [TIME_BITS-1:0] t);
        if (t < 120) return 15;
        if (t < 300) return 30;
        if (t < 1800) return 60;
        if (t < 3600) return 300;
        return 600;
    endfunction

    function automatic logic [TIME_BITS-1:0] add_capped(input logic [TIME_BITS-1:0] a,
                                                        input int unsigned b);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, a} + (TIME_BITS + 1)'(b);
        return sum[TIME_BITS] ? TIME_CAP : sum[TIME_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] sub_floored(input logic [TIME_BITS-1:0] a,
                                                         input int unsigned b);
        return (a > TIME_BITS'(b)) ? a - TIME_BITS'(b) : '0;
    endfunction

    function automatic t_timer_view apply_timer_event(input logic [KIND_W-1:0] kind,
                                                      input logic [VALUE_W-1:0] value,
                                                      input logic fmt);
        t_timer_view view;
        int unsigned stride;
        longint unsigned t;
        case (kind)
            KIND_START: begin
                tmr_stopwatch = (tmr_prog == '0);
                tmr_running   = 1'b1;
                tmr_cur       = tmr_prog;
            end
            KIND_STOP: begin
                tmr_running = 1'b0;
            end
            KIND_STEP_UP: begin
                if (tmr_running) begin
                    stride  = stride_for(tmr_cur);
                    tmr_cur = add_capped(tmr_cur, stride);
                    if (!tmr_stopwatch) tmr_prog = add_capped(tmr_prog, stride);
                end else begin
                    tmr_prog = add_capped(tmr_prog, stride_for(tmr_prog));
                end
            end
            KIND_STEP_DOWN: begin
                if (tmr_running) begin
                    stride  = stride_for(tmr_cur);
                    tmr_cur = sub_floored(tmr_cur, stride);
                    if (!tmr_stopwatch) tmr_prog = sub_floored(tmr_prog, stride);
                end else begin
                    tmr_prog = sub_floored(tmr_prog, stride_for(tmr_prog));
                end
            end
            KIND_TICK_DOWN: begin
                tmr_cur = sub_floored(tmr_cur, 1);
            end
            KIND_TICK_UP: begin
                tmr_cur = add_capped(tmr_cur, 1);
            end
            KIND_SET_PROG: begin
                tmr_prog = (longint'(value) > longint'(TIME_CAP)) ? TIME_CAP
                                                                 : TIME_BITS'(value);
            end
            default: begin
            end
        endcase
        t = tmr_running ? longint'(tmr_cur) : longint'(tmr_prog);
        if (fmt) begin
            if (t / 3600 == 0) t = ((t / 60) % 60) * 100 + t % 60;
            else t = (t / 3600) * 100 + (t / 60) % 60;
        end
        view.shown     = (t > longint'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(t);
        view.prog_time = (longint'(tmr_prog) > longint'(OUT_MAX)) ? OUT_MAX
                                                                   : OUT_BITS'(tmr_prog);
        view.running   = tmr_running;
        view.stopwatch = tmr_stopwatch;
        return view;
    endfunction

    function automatic int unsigned idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_seconds();
        case ($urandom_range(0, 7))
            0: return VALUE_W'($urandom_range(0, 130));
            1: return VALUE_W'($urandom_range(100, 320));
            2: return VALUE_W'($urandom_range(280, 1820));
            3: return VALUE_W'($urandom_range(1780, 3620));
            4: return VALUE_W'($urandom_range(3580, 400000));
            5: return VALUE_W'(TIME_CAP - $urandom_range(0, 2000));
            6: return '0;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    task automatic offer_event(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                               input logic fmt, input logic fixed = 1'b0,
                               input t_timer_view view = '0);
        t_timer_view predicted;
        int unsigned gap;
        if ($urandom_range(0, 149) == 0) tx_calm = !tx_calm;
        if (!tx_calm && $urandom_range(0, 99) < 25) begin
            gap = idle_len();
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_TDATA_W'({fmt, value});
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = apply_timer_event(kind, value, fmt);
        expected_views.push_back(fixed ? view : predicted);
        events_sent++;
        kind_hits[kind]++;
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_views.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_scenario();
        int unsigned sel;
        int unsigned len;
        int unsigned r;
        logic [KIND_W-1:0] k;
        sel = $urandom_range(0, 9);
        len = $urandom_range(3, 20);
        if (sel < 4) begin
            offer_event(KIND_SET_PROG, pick_seconds(), rand_bit());
            offer_event(KIND_START, VALUE_W'($urandom), rand_bit());
            repeat (len) begin
                r = $urandom_range(0, 9);
                case (r)
                    0, 1, 2, 3, 4: k = KIND_TICK_DOWN;
                    5: k = KIND_TICK_UP;
                    6: k = KIND_STEP_UP;
                    7: k = KIND_STEP_DOWN;
                    8: k = KIND_SET_PROG;
                    default: k = KIND_START;
                endcase
                offer_event(k, (k == KIND_SET_PROG) ? pick_seconds() : VALUE_W'($urandom),
                            rand_bit());
            end
            offer_event(KIND_STOP, VALUE_W'($urandom), rand_bit());
        end else if (sel < 6) begin
            offer_event(KIND_SET_PROG, '0, rand_bit());
            offer_event(KIND_START, VALUE_W'($urandom), rand_bit());
            repeat (len) begin
                r = $urandom_range(0, 9);
                case (r)
                    0, 1, 2, 3, 4: k = KIND_TICK_UP;
                    5: k = KIND_TICK_DOWN;
                    6: k = KIND_STEP_UP;
                    7: k = KIND_STEP_DOWN;
                    8: k = KIND_SET_PROG;
                    default: k = KIND_STOP;
                endcase
                offer_event(k, (k == KIND_SET_PROG) ? pick_seconds() : VALUE_W'($urandom),
                            rand_bit());
            end
            offer_event(KIND_STOP, VALUE_W'($urandom), rand_bit());
        end else if (sel < 8) begin
            offer_event(KIND_STOP, VALUE_W'($urandom), rand_bit());
            offer_event(KIND_SET_PROG, pick_seconds(), rand_bit());
            repeat (len) begin
                r = $urandom_range(0, 5);
                case (r)
                    0, 1: k = KIND_STEP_UP;
                    2, 3: k = KIND_STEP_DOWN;
                    4: k = KIND_TICK_DOWN;
                    default: k = KIND_TICK_UP;
                endcase
                offer_event(k, VALUE_W'($urandom), rand_bit());
            end
        end else begin
            repeat (len) begin
                offer_event(KIND_W'($urandom_range(0, 7)), VALUE_W'($urandom),
                            rand_bit());
            end
        end
        if ($urandom_range(0, 19) == 0) drain_results();
    endtask

    initial begin : rx_pacing
        int unsigned stall_left;
        bit calm;
        stall_left = 0;
        calm = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall_left  = RX_HOLD_CYCLES;
            end
            if ($urandom_range(0, 199) == 0) calm = !calm;
            if (stall_left == 0 && !calm && $urandom_range(0, 99) < 25) stall_left = idle_len();
            if (stall_left != 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_timer_view got;
        t_timer_view want;
        got.shown     = o_m_axis_tdata[OUT_BITS-1:0];
        got.prog_time = o_m_axis_tdata[2*OUT_BITS-1:OUT_BITS];
        got.running   = o_m_axis_tdata[2*OUT_BITS];
        got.stopwatch = o_m_axis_tdata[2*OUT_BITS+1];
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_views.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("Unexpected result transfer: shown %0d program %0d run %b sw %b",
                             got.shown, got.prog_time, got.running, got.stopwatch);
                end
            end else begin
                want = expected_views.pop_front();
                views_checked++;
                if (got.shown !== want.shown || got.prog_time !== want.prog_time ||
                    got.running !== want.running || got.stopwatch !== want.stopwatch) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("Result %0d mismatch: expected shown %0d program %0d ",
                                 views_checked, want.shown, want.prog_time,
                                 "run %b sw %b, got shown %0d program %0d run %b sw %b",
                                 want.running, want.stopwatch, got.shown, got.prog_time,
                                 got.running, got.stopwatch);
                    end
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        bit hold_done;
        hold_done     = 1'b0;
        tmr_prog      = '0;
        tmr_cur       = '0;
        tmr_running   = 1'b0;
        tmr_stopwatch = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS_N; i++) begin
            offer_event(DIR_ROWS[i].kind, DIR_ROWS[i].value, DIR_ROWS[i].fmt,
                        DIR_ROWS[i].fixed, DIR_ROWS[i].view);
        end
        drain_results();

        while (events_sent < EVENT_TARGET) begin
            if (!hold_done && events_sent >= HOLD_AT_EVENT) begin
                hold_done   = 1'b1;
                rx_hold_req = 1'b1;
            end
            run_scenario();
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d timer events and checked %0d results, ",
                 events_sent, views_checked,
                 "with one %0d-cycle output hold-off.", RX_HOLD_CYCLES);
        $display("Starts %0d, stops %0d, steps %0d, ticks %0d, program loads %0d, ",
                 kind_hits[KIND_START], kind_hits[KIND_STOP],
                 kind_hits[KIND_STEP_UP] + kind_hits[KIND_STEP_DOWN],
                 kind_hits[KIND_TICK_UP] + kind_hits[KIND_TICK_DOWN],
                 kind_hits[KIND_SET_PROG], "unused kind %0d.", kind_hits[KIND_UNUSED]);
        if (mismatch_count == 0 && expected_views.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/ktsc_pkg.sv
rtl/core/ktsc_state.sv
rtl/core/ktsc_fmt.sv
rtl/core/kitchen_timer_stopwatch_control_top.sv
test/kitchen_timer_stopwatch_control_top_tb.sv
